### rtl/core/ntb_pkg.sv
// shared constants and types for the nonzero time-slice batcher
`timescale 1ns / 1ps

package ntb_pkg;

   localparam int COORD_MODES = 3;
   localparam int COORD_BITS  = 32;
   localparam int MAX_MODES   = 3;

   localparam logic [31:0] COORD_MASK =
      (COORD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COORD_BITS) - 64'd1);

   localparam logic [31:0] ITEM_THRESHOLD_RESET = 32'd1024;
   localparam logic [31:0] SLICE_LIMIT_RESET    = 32'd1;

   typedef enum logic {
      CSR_ITEM_THRESHOLD = 1'b0,
      CSR_SLICE_LIMIT    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REBASED = 2'd1,
      STATUS_ORDER   = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] batch_number;
      logic        first_of_batch;
      logic [31:0] rel_time;
      logic [32:0] extent_a;
      logic [32:0] extent_b;
      logic [32:0] extent_c;
      logic [31:0] value_out;
      status_type  status;
   } rsp_type;

endpackage

### rtl/core/nonzero_timeslice_batcher.sv
// top level: groups time-sorted tensor nonzeros into batches of whole time slices
`timescale 1ns / 1ps

// Nonzeros enter on the req_ channel (valid/ready), sorted by time_index, and
// each item gives exactly one result on the rsp_ channel (valid/ready).
// The batch state and per-mode extents update in the cycle an item is
// accepted; the result lands in an output register, so rsp_valid rises in
// the next cycle, and throughput is one item per cycle with rsp_ready high.
// The output register holds a result while the receiver stalls; req_ready
// stays high while that register is empty or is being taken in the same
// cycle, so items flow back to back with rsp_ready high.
// The user writes item_threshold and slice_limit through csr_wr_en /
// csr_index / csr_wr_data only while the block is idle; the block does not
// enforce this. A write takes effect on the next item. Synchronous reset
// clears batch state, extents and output valid, and restores item_threshold
// to 1024 and slice_limit to 1; no clearing pass. status reports a rebased
// (skipped empty) batch or an out-of-order time, treated as the last slice.
module nonzero_timeslice_batcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_time_index,
   input  logic [31:0] req_coord_a,
   input  logic [31:0] req_coord_b,
   input  logic [31:0] req_coord_c,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_batch_number,
   output logic        rsp_first_of_batch,
   output logic [31:0] rsp_rel_time,
   output logic [32:0] rsp_extent_a,
   output logic [32:0] rsp_extent_b,
   output logic [32:0] rsp_extent_c,
   output logic [31:0] rsp_value_out,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   logic [31:0] item_threshold_ff;
   logic [31:0] slice_limit_ff;

   logic [31:0] batch_start_ff, batch_start_in;
   logic [31:0] last_slice_ff, last_slice_in;
   logic        slice_seen_ff;
   logic [31:0] items_in_batch_ff, items_in_batch_in;
   logic [31:0] batch_counter_ff, batch_counter_in;
   logic [32:0] mode_extent_ff [ntb_pkg::MAX_MODES];
   logic [32:0] mode_extent_in [ntb_pkg::MAX_MODES];

   logic                 rsp_valid_ff;
   ntb_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 req_accept;
   logic [31:0]          lim;
   logic [31:0]          t_eff;
   logic                 over_thr;
   logic                 closing;
   logic                 opening;
   logic [32:0]          cand_start;
   logic [33:0]          cand_diff;
   logic                 rebase;
   ntb_pkg::status_type  status;
   logic [31:0]          coord [ntb_pkg::MAX_MODES];
   logic [32:0]          coord_ext [ntb_pkg::MAX_MODES];

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign coord[0] = req_coord_a;
   assign coord[1] = req_coord_b;
   assign coord[2] = req_coord_c;

   always_comb begin
      lim      = (slice_limit_ff == 32'd0) ? 32'd1 : slice_limit_ff;
      status   = ntb_pkg::STATUS_OK;
      t_eff    = req_time_index;
      if (slice_seen_ff && (req_time_index < last_slice_ff)) begin
         t_eff  = last_slice_ff;
         status = ntb_pkg::STATUS_ORDER;
      end
      over_thr = items_in_batch_ff >= item_threshold_ff;
      closing  = slice_seen_ff && (t_eff > last_slice_ff) &&
                 (over_thr || ((t_eff - batch_start_ff) >= lim));
      opening  = !slice_seen_ff || closing;

      // first batch opens at time 0 unless rebased
      if (!slice_seen_ff) begin
         cand_start = 33'd0;
      end else if (over_thr) begin
         cand_start = {1'b0, last_slice_ff} + 33'd1;
      end else begin
         cand_start = {1'b0, batch_start_ff} + {1'b0, lim};
      end
      // start past the item, or too far behind it, would leave the batch empty
      cand_diff = {2'b00, t_eff} - {1'b0, cand_start};
      rebase    = cand_diff[33] || (cand_diff[32:0] >= {1'b0, lim});

      batch_start_in    = batch_start_ff;
      items_in_batch_in = items_in_batch_ff;
      batch_counter_in  = batch_counter_ff;
      if (opening) begin
         items_in_batch_in = 32'd1;
         batch_start_in    = rebase ? t_eff : cand_start[31:0];
         if (rebase) begin
            status = ntb_pkg::STATUS_REBASED;
         end
         if (slice_seen_ff) begin
            batch_counter_in = batch_counter_ff + 32'd1;
         end
      end else if (items_in_batch_ff != 32'hFFFF_FFFF) begin
         items_in_batch_in = items_in_batch_ff + 32'd1;
      end
      last_slice_in = t_eff;

      for (int m = 0; m < ntb_pkg::MAX_MODES; m++) begin
         coord_ext[m]      = {1'b0, coord[m] & ntb_pkg::COORD_MASK} + 33'd1;
         mode_extent_in[m] = mode_extent_ff[m];
         if ((m < ntb_pkg::COORD_MODES) && (coord_ext[m] > mode_extent_ff[m])) begin
            mode_extent_in[m] = coord_ext[m];
         end
      end

      rsp_in.batch_number   = batch_counter_in;
      rsp_in.first_of_batch = opening;
      rsp_in.rel_time       = t_eff - batch_start_in;
      rsp_in.extent_a       = mode_extent_in[0];
      rsp_in.extent_b       = mode_extent_in[1];
      rsp_in.extent_c       = mode_extent_in[2];
      rsp_in.value_out      = req_value_bits;
      rsp_in.status         = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_threshold_ff <= ntb_pkg::ITEM_THRESHOLD_RESET;
         slice_limit_ff    <= ntb_pkg::SLICE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ntb_pkg::CSR_ITEM_THRESHOLD: item_threshold_ff <= csr_wr_data;
            ntb_pkg::CSR_SLICE_LIMIT:    slice_limit_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_start_ff    <= 32'd0;
         last_slice_ff     <= 32'd0;
         slice_seen_ff     <= 1'b0;
         items_in_batch_ff <= 32'd0;
         batch_counter_ff  <= 32'd0;
         for (int m = 0; m < ntb_pkg::MAX_MODES; m++) begin
            mode_extent_ff[m] <= 33'd0;
         end
      end else if (req_accept) begin
         batch_start_ff    <= batch_start_in;
         last_slice_ff     <= last_slice_in;
         slice_seen_ff     <= 1'b1;
         items_in_batch_ff <= items_in_batch_in;
         batch_counter_ff  <= batch_counter_in;
         for (int m = 0; m < ntb_pkg::MAX_MODES; m++) begin
            mode_extent_ff[m] <= mode_extent_in[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_batch_number   = rsp_ff.batch_number;
   assign rsp_first_of_batch = rsp_ff.first_of_batch;
   assign rsp_rel_time       = rsp_ff.rel_time;
   assign rsp_extent_a       = rsp_ff.extent_a;
   assign rsp_extent_b       = rsp_ff.extent_b;
   assign rsp_extent_c       = rsp_ff.extent_c;
   assign rsp_value_out      = rsp_ff.value_out;
   assign rsp_status         = rsp_ff.status;

`ifndef SYNTHESIS
   // the open batch never starts after the last slice it has taken
   assert property (@(posedge clock) disable iff (reset)
      slice_seen_ff |-> (batch_start_ff <= last_slice_ff))
      else $error("batch start past last slice");

   // batch number moves by at most one per item
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && slice_seen_ff) |=>
         ((rsp_batch_number == $past(batch_counter_ff)) ||
          (rsp_batch_number == $past(batch_counter_ff) + 32'd1)))
      else $error("batch number jumped");

   // a rebased start always opens a batch
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ntb_pkg::STATUS_REBASED)) |-> rsp_first_of_batch)
      else $error("rebase without new batch");

   // input only stalls behind a held result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled with output free");
`endif

endmodule

### tb/sv/nonzero_timeslice_batcher_test.sv
// self-checking testbench for the nonzero time-slice batcher: directed rows around random streams
`timescale 1ns / 1ps

module nonzero_timeslice_batcher_test;

   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 75;
   localparam int HOLD_CYCLES   = 60;
   localparam int DIR_ROWS      = 20;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [32:0] EXT_TOP  = 33'h1_0000_0000;
   localparam ntb_pkg::rsp_type NO_RSP = '0;

   typedef struct packed {
      logic            set_regs;
      logic [31:0]     threshold;
      logic [31:0]     slice_limit;
      logic [31:0]     time_index;
      logic [31:0]     coord_a;
      logic [31:0]     coord_b;
      logic [31:0]     coord_c;
      logic [31:0]     value_bits;
      logic            typed;
      ntb_pkg::rsp_type want;
   } nz_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [31:0] req_time_index = '0;
   logic [31:0] req_coord_a    = '0;
   logic [31:0] req_coord_b    = '0;
   logic [31:0] req_coord_c    = '0;
   logic [31:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_batch_number;
   logic        rsp_first_of_batch;
   logic [31:0] rsp_rel_time;
   logic [32:0] rsp_extent_a;
   logic [32:0] rsp_extent_b;
   logic [32:0] rsp_extent_c;
   logic [31:0] rsp_value_out;
   logic [1:0]  rsp_status;
   logic        csr_wr_en      = 1'b0;
   logic        csr_index      = ntb_pkg::CSR_ITEM_THRESHOLD;
   logic [31:0] csr_wr_data    = '0;

   // shadow of the batcher state and its registers
   logic [31:0] cfg_threshold   = ntb_pkg::ITEM_THRESHOLD_RESET;
   logic [31:0] cfg_slice_limit = ntb_pkg::SLICE_LIMIT_RESET;
   logic [31:0] shadow_start    = '0;
   logic [31:0] shadow_last     = '0;
   logic        shadow_seen     = 1'b0;
   logic [31:0] shadow_items    = '0;
   logic [31:0] shadow_batch    = '0;
   logic [32:0] shadow_extent [3] = '{default: '0};

   ntb_pkg::rsp_type due_tags [$];
   logic [31:0] stream_time = '0;
   int errors          = 0;
   int items_sent      = 0;
   int tags_checked    = 0;
   int rebased_seen    = 0;
   int disorder_seen   = 0;
   int settings_used   = 0;
   int snd_idle_pct    = 36;
   int rcv_idle_pct    = 53;
   int hold_requests   = 0;
   int hold_served     = 0;
   int hold_left       = 0;

   // time 2 as first item rebases the very first batch
   nz_row_type dir_rows [DIR_ROWS] = '{
      '{1'b0, '0, '0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{32'd0, 1'b1, 32'd0, 33'd1, 33'd1, 33'd1, 32'd0, ntb_pkg::STATUS_REBASED}},
      '{1'b0, '0, '0, 32'd2, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
        '{32'd0, 1'b0, 32'd0, EXT_TOP, EXT_TOP, EXT_TOP, ALL_ONES, ntb_pkg::STATUS_OK}},
      '{1'b0, '0, '0, 32'd3, 32'd5, 32'd5, 32'd5, 32'h3F80_0000, 1'b1,
        '{32'd1, 1'b1, 32'd0, EXT_TOP, EXT_TOP, EXT_TOP, 32'h3F80_0000,
          ntb_pkg::STATUS_OK}},
      '{1'b0, '0, '0, 32'd7, 32'd7, 32'd7, 32'd7, 32'h8000_0000, 1'b1,
        '{32'd2, 1'b1, 32'd0, EXT_TOP, EXT_TOP, EXT_TOP, 32'h8000_0000,
          ntb_pkg::STATUS_REBASED}},
      '{1'b0, '0, '0, 32'd5, 32'd2, 32'd2, 32'd2, 32'h7F80_0000, 1'b1,
        '{32'd2, 1'b0, 32'd0, EXT_TOP, EXT_TOP, EXT_TOP, 32'h7F80_0000,
          ntb_pkg::STATUS_ORDER}},
      '{1'b1, 32'd2, 32'd3, 32'd7, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'd1,
        1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd8, 32'd1, 32'd2, 32'd3, 32'd2, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd9, 32'd9, 32'd8, 32'd7, 32'd3, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd9, 32'd0, 32'd0, 32'd0, 32'd4, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd10, 32'd4, 32'd4, 32'd4, 32'd5, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd25, 32'd6, 32'd6, 32'd6, 32'd6, 1'b0, NO_RSP},
      '{1'b1, 32'd0, 32'd0, 32'd26, 32'd1, 32'd1, 32'd1, 32'd7, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd26, 32'd2, 32'd2, 32'd2, 32'd8, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd27, 32'd3, 32'd3, 32'd3, 32'd9, 1'b0, NO_RSP},
      '{1'b1, ALL_ONES, ALL_ONES, 32'd30, 32'd10, 32'd11, 32'd12, 32'd10, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd1000, 32'd13, 32'd14, 32'd15, 32'd11, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd900, 32'd16, 32'd17, 32'd18, 32'd12, 1'b0, NO_RSP},
      '{1'b1, 32'd1024, 32'd1, 32'd1001, 32'd19, 32'd20, 32'd21, 32'd13, 1'b0, NO_RSP},
      // top of the time range, then a time that can only be out of order
      '{1'b0, '0, '0, ALL_ONES, 32'hFFFF_FFFE, 32'h0, 32'h8000_0001, 32'd14, 1'b0, NO_RSP},
      '{1'b0, '0, '0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd15, 1'b0, NO_RSP}
   };

   nonzero_timeslice_batcher DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_time_index     (req_time_index),
      .req_coord_a        (req_coord_a),
      .req_coord_b        (req_coord_b),
      .req_coord_c        (req_coord_c),
      .req_value_bits     (req_value_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_batch_number   (rsp_batch_number),
      .rsp_first_of_batch (rsp_first_of_batch),
      .rsp_rel_time       (rsp_rel_time),
      .rsp_extent_a       (rsp_extent_a),
      .rsp_extent_b       (rsp_extent_b),
      .rsp_extent_c       (rsp_extent_c),
      .rsp_value_out      (rsp_value_out),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
   endtask

   // advances the shadow state by one nonzero and returns its batch tag
   function automatic ntb_pkg::rsp_type batch_next_tag(input logic [31:0] t_in, ca, cb, cc,
                                                       vbits);
      ntb_pkg::rsp_type tag;
      logic [63:0] t;
      logic [63:0] lim;
      logic [63:0] thr;
      logic [31:0] coords [3];
      logic [32:0] ext;
      t = {32'd0, t_in};
      lim = (cfg_slice_limit == 32'd0) ? 64'd1 : {32'd0, cfg_slice_limit};
      thr = {32'd0, cfg_threshold};
      coords[0] = ca;
      coords[1] = cb;
      coords[2] = cc;
      tag = NO_RSP;
      tag.status = ntb_pkg::STATUS_OK;
      if (!shadow_seen) begin
         shadow_start = '0;
         if (t >= lim) begin
            shadow_start = t_in;
            tag.status = ntb_pkg::STATUS_REBASED;
         end
         tag.first_of_batch = 1'b1;
         shadow_items = 32'd1;
         shadow_seen = 1'b1;
      end else begin
         if (t < {32'd0, shadow_last}) begin
            t = {32'd0, shadow_last};
            tag.status = ntb_pkg::STATUS_ORDER;
         end
         if (t > {32'd0, shadow_last} &&
             ({32'd0, shadow_items} >= thr || t - {32'd0, shadow_start} >= lim)) begin
            if ({32'd0, shadow_items} >= thr) shadow_start = shadow_last + 32'd1;
            else shadow_start = shadow_start + lim[31:0];
            // the new batch would hold nothing: restart it at this item
            if (t - {32'd0, shadow_start} >= lim) begin
               shadow_start = t[31:0];
               tag.status = ntb_pkg::STATUS_REBASED;
            end
            shadow_batch = shadow_batch + 32'd1;
            tag.first_of_batch = 1'b1;
            shadow_items = 32'd1;
         end else if (shadow_items != ALL_ONES) begin
            shadow_items = shadow_items + 32'd1;
         end
      end
      shadow_last = t[31:0];
      for (int m = 0; m < ntb_pkg::COORD_MODES; m++) begin
         ext = {1'b0, coords[m] & ntb_pkg::COORD_MASK} + 33'd1;
         if (ext > shadow_extent[m]) shadow_extent[m] = ext;
      end
      tag.batch_number = shadow_batch;
      tag.rel_time = t[31:0] - shadow_start;
      tag.extent_a = (ntb_pkg::COORD_MODES > 0) ? shadow_extent[0] : '0;
      tag.extent_b = (ntb_pkg::COORD_MODES > 1) ? shadow_extent[1] : '0;
      tag.extent_c = (ntb_pkg::COORD_MODES > 2) ? shadow_extent[2] : '0;
      tag.value_out = vbits;
      return tag;
   endfunction

   task automatic compare_tag(input ntb_pkg::rsp_type want);
      if (rsp_batch_number !== want.batch_number)
         flag_mismatch($sformatf("batch_number got %0d want %0d",
                                 rsp_batch_number, want.batch_number));
      if (rsp_first_of_batch !== want.first_of_batch)
         flag_mismatch($sformatf("first_of_batch got %b want %b",
                                 rsp_first_of_batch, want.first_of_batch));
      if (rsp_rel_time !== want.rel_time)
         flag_mismatch($sformatf("rel_time got %0d want %0d", rsp_rel_time, want.rel_time));
      if (rsp_extent_a !== want.extent_a)
         flag_mismatch($sformatf("extent_a got %h want %h", rsp_extent_a, want.extent_a));
      if (rsp_extent_b !== want.extent_b)
         flag_mismatch($sformatf("extent_b got %h want %h", rsp_extent_b, want.extent_b));
      if (rsp_extent_c !== want.extent_c)
         flag_mismatch($sformatf("extent_c got %h want %h", rsp_extent_c, want.extent_c));
      if (rsp_value_out !== want.value_out)
         flag_mismatch($sformatf("value_out got %h want %h", rsp_value_out, want.value_out));
      if (rsp_status !== want.status)
         flag_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (want.status == ntb_pkg::STATUS_REBASED) rebased_seen++;
      if (want.status == ntb_pkg::STATUS_ORDER) disorder_seen++;
      tags_checked++;
   endtask

   // result side: checks each taken item, then picks the next ready
   always @(posedge clock) begin
      ntb_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_tags.size() == 0) begin
               flag_mismatch("result arrived with nothing expected");
            end else begin
               want = due_tags.pop_front();
               compare_tag(want);
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   task automatic wait_drain();
      while (due_tags.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] thr, lim);
      csr_wr_en   <= 1'b1;
      csr_index   <= ntb_pkg::CSR_ITEM_THRESHOLD;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_index   <= ntb_pkg::CSR_SLICE_LIMIT;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_threshold   = thr;
      cfg_slice_limit = lim;
      settings_used++;
   endtask

   // offers one item and records its expected tag once it is taken
   task automatic offer_nonzero(input logic [31:0] t, ca, cb, cc, vbits,
                                input logic typed, input ntb_pkg::rsp_type typed_tag);
      ntb_pkg::rsp_type tag;
      // idle cycle by cycle so the sender sits out about snd_idle_pct of its cycles
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_time_index <= t;
      req_coord_a    <= ca;
      req_coord_b    <= cb;
      req_coord_c    <= cc;
      req_value_bits <= vbits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tag = batch_next_tag(t, ca, cb, cc, vbits);
      if (typed) tag = typed_tag;
      due_tags = {due_tags, tag};
      if (t > stream_time) stream_time = t;
      items_sent++;
   endtask

   task automatic run_rows(input int first_row, input int last_row);
      nz_row_type row;
      for (int i = first_row; i <= last_row; i++) begin
         row = dir_rows[i];
         if (row.set_regs) begin
            req_valid <= 1'b0;
            wait_drain();
            program_regs(row.threshold, row.slice_limit);
         end
         offer_nonzero(row.time_index, row.coord_a, row.coord_b, row.coord_c,
                       row.value_bits, row.typed, row.want);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      if ($urandom_range(0, 99) < 60) return $urandom_range(0, 300);
      return $urandom;
   endfunction

   initial begin
      int          roll;
      logic [31:0] t;
      logic [31:0] thr;
      logic [31:0] lim;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // the last two rows pin time at its top, so they run at the very end
      run_rows(0, DIR_ROWS - 3);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 2)
            0: begin
               snd_idle_pct = 36;
               rcv_idle_pct = 53;
            end
            1: begin
               snd_idle_pct = 53;
               rcv_idle_pct = 36;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         case (p)
            0: begin thr = 32'd4;  lim = 32'd2; end
            1: begin thr = 32'd1;  lim = 32'd1; end
            2: begin thr = 32'd12; lim = 32'd6; end
            3: begin thr = ALL_ONES; lim = 32'd3; end
            4: begin thr = 32'd2;  lim = ALL_ONES; end
            default: begin
               thr = $urandom_range(1, 20);
               lim = $urandom_range(1, 10);
            end
         endcase
         req_valid <= 1'b0;
         wait_drain();
         program_regs(thr, lim);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // long receiver stall while items keep coming
            if (p == 0 && k == 20) hold_requests++;
            if (p == 3 && k == 40) begin
               req_valid <= 1'b0;
               wait_drain();
            end
            roll = $urandom_range(0, 99);
            if (roll < 50) t = stream_time;
            else if (roll < 75) t = stream_time + 32'd1;
            else if (roll < 88) t = stream_time + $urandom_range(2, 3);
            else if (roll < 96) t = stream_time + $urandom_range(4, 30);
            else t = stream_time - $urandom_range(1, 5);
            offer_nonzero(t, pick_coord(), pick_coord(), pick_coord(), $urandom,
                          1'b0, NO_RSP);
         end
      end

      run_rows(DIR_ROWS - 2, DIR_ROWS - 1);
      req_valid <= 1'b0;
      wait_drain();
      repeat (5) @(posedge clock);
      if (due_tags.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", due_tags.size()));

      $display("covered %0d nonzeros under %0d register settings, %0d results checked",
               items_sent, settings_used, tags_checked);
      $display("status seen: %0d empty batches rebased, %0d times out of order",
               rebased_seen, disorder_seen);
      if (errors == 0) begin
         $display("nonzero_timeslice_batcher: match");
      end else begin
         $display("nonzero_timeslice_batcher: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[%0t] error: run timed out", $time);
      $display("nonzero_timeslice_batcher: mismatch");
      $finish;
   end

endmodule

### nonzero_timeslice_batcher.f
rtl/core/ntb_pkg.sv
rtl/core/nonzero_timeslice_batcher.sv
tb/sv/nonzero_timeslice_batcher_test.sv
